// ===== rtl/three_layer_alpha_compositor_macros.svh =====
// Assertion macros for the three-layer alpha compositor.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef THREE_LAYER_ALPHA_COMPOSITOR_MACROS_SVH
`define THREE_LAYER_ALPHA_COMPOSITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlac_pkg.sv =====
// Shared types, constants and the divide-by-255 and mix-sum helpers for the compositor.
// No dependencies.
`timescale 1ns / 1ps

package tlac_pkg;

    localparam int unsigned PIX_W  = 32;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned NUM_CH = 3;

    localparam logic [CH_W-1:0] FULL_ALPHA = 8'hff;
    localparam logic [CH_W-1:0] ZERO_ALPHA = 8'h00;

    typedef enum logic [1:0] {
        MODE_FRAME,
        MODE_CHAR,
        MODE_BKG,
        MODE_BLEND
    } mode_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0]  rgb_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    // floor(x / 255) for x up to 65279 (the result is 8 bits): (x + (x >> 8) + 1) >> 8
    function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[SUM_W-1:CH_W]} + {{SUM_W{1'b0}}, 1'b1};
        return t[SUM_W-1:CH_W];
    endfunction

    // a*alpha + b*(255-alpha); at most 255*255, fits 16 bits
    function automatic logic [SUM_W-1:0] mix_sum(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [CH_W-1:0] alpha);
        logic [SUM_W-1:0] pa;
        logic [SUM_W-1:0] pb;
        pa = SUM_W'(a) * SUM_W'(alpha);
        pb = SUM_W'(b) * SUM_W'(FULL_ALPHA - alpha);
        return pa + pb;
    endfunction

endpackage

// ===== rtl/three_layer_alpha_compositor.sv =====
// Three-layer alpha compositor: frame over character over background.
// Depends on tlac_pkg and three_layer_alpha_compositor_macros.svh.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   input   | in_valid, in_ready, frame_pixel,               | in
//           | character_pixel, background_pixel              |
//   output  | out_valid, out_ready, out_pixel                | out
//
// One word in per cycle, one word out per cycle while the output is taken; words pass
// through four register stages (two multiply-add stages, two divide stages).
// All stages advance together when the output register is empty or taken;
// otherwise the whole pipeline holds and in_ready is low.
// Reset clears the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "three_layer_alpha_compositor_macros.svh"

module three_layer_alpha_compositor
    import tlac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] frame_pixel,
    input  logic [PIX_W-1:0] character_pixel,
    input  logic [PIX_W-1:0] background_pixel,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    logic advance;

    // stage 1: character-over-background products
    logic             s1_valid_reg;
    mode_t            s1_mode_reg;
    logic [PIX_W-1:0] s1_pass_reg;
    rgb_t             s1_frame_reg;
    logic [CH_W-1:0]  s1_fa_reg;
    sums_t            s1_sum_reg;

    // stage 2: intermediate pixel
    logic             s2_valid_reg;
    mode_t            s2_mode_reg;
    logic [PIX_W-1:0] s2_pass_reg;
    rgb_t             s2_frame_reg;
    logic [CH_W-1:0]  s2_fa_reg;
    rgb_t             s2_mid_reg;

    // stage 3: frame-over-intermediate products
    logic             s3_valid_reg;
    mode_t            s3_mode_reg;
    logic [PIX_W-1:0] s3_pass_reg;
    sums_t            s3_sum_reg;

    // stage 4: output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;

    mode_t            s1_mode_next;
    logic [PIX_W-1:0] s1_pass_next;
    sums_t            s1_sum_next;
    rgb_t             s2_mid_next;
    sums_t            s3_sum_next;
    logic [PIX_W-1:0] out_pixel_next;

    logic [CH_W-1:0]  in_fa;
    logic [CH_W-1:0]  in_ca;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign in_fa    = frame_pixel[PIX_W-1 -: CH_W];
    assign in_ca    = character_pixel[PIX_W-1 -: CH_W];

    always_comb
    begin
        priority if (in_fa == FULL_ALPHA)
        begin
            s1_mode_next = MODE_FRAME;
            s1_pass_next = frame_pixel;
        end
        else if (in_fa == ZERO_ALPHA && in_ca == FULL_ALPHA)
        begin
            s1_mode_next = MODE_CHAR;
            s1_pass_next = character_pixel;
        end
        else if (in_fa == ZERO_ALPHA && in_ca == ZERO_ALPHA)
        begin
            s1_mode_next = MODE_BKG;
            s1_pass_next = background_pixel;
        end
        else
        begin
            s1_mode_next = MODE_BLEND;
            s1_pass_next = background_pixel;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            s1_sum_next[c] = mix_sum(character_pixel[c*CH_W +: CH_W],
                                     background_pixel[c*CH_W +: CH_W], in_ca);
            s2_mid_next[c] = div255(s1_sum_reg[c]);
            s3_sum_next[c] = mix_sum(s2_frame_reg[c], s2_mid_reg[c], s2_fa_reg);
        end
    end

    always_comb
    begin
        unique case (s3_mode_reg)
            MODE_BLEND:
            begin
                out_pixel_next = {FULL_ALPHA, div255(s3_sum_reg[2]),
                                  div255(s3_sum_reg[1]), div255(s3_sum_reg[0])};
            end
            default:
            begin
                out_pixel_next = s3_pass_reg;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // payload; hold everything while the output word waits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg   <= s1_mode_next;
            s1_pass_reg   <= s1_pass_next;
            s1_frame_reg  <= frame_pixel[NUM_CH*CH_W-1:0];
            s1_fa_reg     <= in_fa;
            s1_sum_reg    <= s1_sum_next;

            s2_mode_reg   <= s1_mode_reg;
            s2_pass_reg   <= s1_pass_reg;
            s2_frame_reg  <= s1_frame_reg;
            s2_fa_reg     <= s1_fa_reg;
            s2_mid_reg    <= s2_mid_next;

            s3_mode_reg   <= s2_mode_reg;
            s3_pass_reg   <= s2_pass_reg;
            s3_sum_reg    <= s3_sum_next;

            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    `TLAC_ASSERT_NEXT(a_accept_enters_s1, in_valid && in_ready, s1_valid_reg,
        "accepted word did not reach stage 1")
    `TLAC_ASSERT_NEXT(a_stall_freezes_pipe, !in_ready,
        $stable(s1_valid_reg) && $stable(s2_valid_reg) && $stable(s3_valid_reg),
        "pipeline moved during a stall")
    `TLAC_ASSERT_NEXT(a_blend_alpha_full, advance && s3_valid_reg && s3_mode_reg == MODE_BLEND,
        out_pixel[PIX_W-1 -: CH_W] == FULL_ALPHA,
        "blended word without full alpha")
    `TLAC_ASSERT_NOW(a_pass_frame_alpha, s1_valid_reg && s1_mode_reg == MODE_FRAME,
        s1_fa_reg == FULL_ALPHA && s1_pass_reg[PIX_W-1 -: CH_W] == FULL_ALPHA,
        "frame pass-through chosen for a non-opaque frame")

endmodule

// ===== bench/tb_three_layer_alpha_compositor.sv =====
// Testbench for three_layer_alpha_compositor: directed and random pixel words checked
// against a built-in compositing predictor. Depends on tlac_pkg and the compositor RTL.
`timescale 1ns / 1ps

module tb_three_layer_alpha_compositor;
    import tlac_pkg::*;

    localparam int unsigned STALL_PCT      = 17;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned RANDOM_PIXELS  = 1000;
    localparam int unsigned STREAM_PIXELS  = 200;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } rgba_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [PIX_W-1:0] frame_pixel;
    logic [PIX_W-1:0] character_pixel;
    logic [PIX_W-1:0] background_pixel;
    logic             out_valid;
    logic             out_ready;
    logic [PIX_W-1:0] out_pixel;

    rgba_t       composited_q[$];
    rgba_t       head_pixel;
    bit          steady;
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned pixels_seen;
    int unsigned quiet_cycles;
    int unsigned mode_hits[4];

    three_layer_alpha_compositor i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frame_pixel      (frame_pixel),
        .character_pixel  (character_pixel),
        .background_pixel (background_pixel),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_pixel        (out_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor((top*alpha + bottom*(255-alpha)) / 255) for one channel
    function automatic logic [CH_W-1:0] weigh(input logic [CH_W-1:0] top,
                                              input logic [CH_W-1:0] bottom,
                                              input logic [CH_W-1:0] alpha);
        int unsigned full;
        int unsigned num;
        full = int'(FULL_ALPHA);
        num  = int'(top) * int'(alpha) + int'(bottom) * (full - int'(alpha));
        return CH_W'(num / full);
    endfunction

    function automatic rgba_t layer_over(input rgba_t top, input rgba_t bottom,
                                         input logic [CH_W-1:0] alpha);
        rgba_t res;
        res.r = weigh(top.r, bottom.r, alpha);
        res.g = weigh(top.g, bottom.g, alpha);
        res.b = weigh(top.b, bottom.b, alpha);
        res.a = FULL_ALPHA;
        return res;
    endfunction

    function automatic mode_t pick_mode(input rgba_t frm, input rgba_t chr);
        if (frm.a == FULL_ALPHA)
            return MODE_FRAME;
        else if (frm.a == ZERO_ALPHA && chr.a == FULL_ALPHA)
            return MODE_CHAR;
        else if (frm.a == ZERO_ALPHA && chr.a == ZERO_ALPHA)
            return MODE_BKG;
        else
            return MODE_BLEND;
    endfunction

    function automatic rgba_t composite(input rgba_t frm, input rgba_t chr, input rgba_t bkg);
        case (pick_mode(frm, chr))
            MODE_FRAME: return frm;
            MODE_CHAR:  return chr;
            MODE_BKG:   return bkg;
            default:    return layer_over(frm, layer_over(chr, bkg, chr.a), frm.a);
        endcase
    endfunction

    // Bias alpha toward the values that select a special path.
    function automatic logic [CH_W-1:0] pick_alpha();
        case ($urandom_range(5))
            0:       return ZERO_ALPHA;
            1:       return FULL_ALPHA;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    function automatic rgba_t rand_pixel(input logic [CH_W-1:0] alpha);
        rgba_t px;
        px   = rgba_t'($urandom());
        px.a = alpha;
        return px;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_pixel(input rgba_t frm, input rgba_t chr, input rgba_t bkg);
        mode_t m;
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        frame_pixel      = frm;
        character_pixel  = chr;
        background_pixel = bkg;
        in_valid         = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        m = pick_mode(frm, chr);
        mode_hits[int'(m)]++;
        composited_q.push_back(composite(frm, chr, bkg));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic test_opaque_frame();
        push_pixel(32'hff000000, rand_pixel(8'h80), rand_pixel(8'h40));
        push_pixel(32'hffffffff, 32'hffffffff, 32'h00000000);
        push_pixel(32'hff5aa53c, 32'h00000000, 32'hffffffff);
    endtask

    task automatic test_clear_frame();
        // opaque character passes whole, clear character passes the background alpha too
        push_pixel(32'h00ffffff, 32'hff123456, rand_pixel(8'h00));
        push_pixel(32'h00000000, 32'hffffffff, 32'h00000000);
        push_pixel(32'h00ffffff, 32'h00ffffff, 32'h5a010203);
        push_pixel(32'h00000000, 32'h00000000, 32'hffffffff);
        // partial character with clear frame still blends
        push_pixel(32'h00ffffff, 32'h80ffffff, 32'h00000000);
        push_pixel(32'h00000000, 32'h01ffffff, 32'h7fffffff);
        push_pixel(32'h00ffffff, 32'hfe000000, 32'hffffffff);
    endtask

    task automatic test_blend_edges();
        push_pixel(32'h01ffffff, 32'h00000000, 32'h00ffffff);
        push_pixel(32'hfe000000, 32'hffffffff, 32'h00000000);
        push_pixel(32'h80ffffff, 32'h80000000, 32'h00ffffff);
        push_pixel(32'h80000000, 32'h80ffffff, 32'hff000000);
        push_pixel(32'h01010101, 32'h01fefefe, 32'h00808080);
        push_pixel(32'hfeffffff, 32'h00ffffff, 32'h00ffffff);
        // background alpha must not act as a weight
        push_pixel(32'h4060a0c0, 32'h7f304050, 32'h00112233);
        push_pixel(32'h4060a0c0, 32'h7f304050, 32'hff112233);
        push_pixel(32'h4060a0c0, 32'h7f304050, 32'h80112233);
    endtask

    task automatic test_random_pixels();
        for (int unsigned i = 0; i < RANDOM_PIXELS; i++)
            push_pixel(rand_pixel(pick_alpha()), rand_pixel(pick_alpha()),
                       rgba_t'($urandom()));
    endtask

    task automatic test_full_rate_stream();
        steady = 1'b1;
        for (int unsigned i = 0; i < STREAM_PIXELS; i++)
            push_pixel(rand_pixel(pick_alpha()), rand_pixel(pick_alpha()),
                       rgba_t'($urandom()));
        steady = 1'b0;
    endtask

    // hold ready low while in reset, then drop it at random
    always @(negedge clk)
        out_ready = rst_n && (steady || ($urandom_range(99) >= STALL_PCT));

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen++;
            if (composited_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word out_pixel=%08h", $realtime, out_pixel);
            end
            else
            begin
                head_pixel = composited_q.pop_front();
                if (out_pixel !== head_pixel)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: out_pixel mismatch, expected %08h actual %08h",
                                 $realtime, head_pixel, out_pixel);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Stalled %0d cycles with %0d words outstanding",
                         quiet_cycles, composited_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        frame_pixel      = '0;
        character_pixel  = '0;
        background_pixel = '0;
        steady           = 1'b0;
        mismatches       = 0;
        pixels_sent      = 0;
        pixels_seen      = 0;
        quiet_cycles     = 0;
        foreach (mode_hits[i])
            mode_hits[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_opaque_frame();
        test_clear_frame();
        test_blend_edges();
        test_random_pixels();
        test_full_rate_stream();
        in_valid = 1'b0;

        // drain, then let any stray word show up
        while (composited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels, received %0d, %0d mismatches", pixels_sent, pixels_seen,
                 mismatches);
        $display("Paths hit: frame %0d, character %0d, background %0d, blend %0d",
                 mode_hits[int'(MODE_FRAME)], mode_hits[int'(MODE_CHAR)],
                 mode_hits[int'(MODE_BKG)], mode_hits[int'(MODE_BLEND)]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tlac_pkg.sv
rtl/three_layer_alpha_compositor.sv
bench/tb_three_layer_alpha_compositor.sv
